### rtl/mlp_forward_pass_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MLP_FORWARD_PASS_CORE_DEFINES_SVH
`define MLP_FORWARD_PASS_CORE_DEFINES_SVH

// Clocked property, ignored while reset is high.
`define MFP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define MFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg
// Types, constants and the sigmoid table of the MLP forward-pass core.
// ----------------------------------------------------------------------------
package mfp_pkg;

  localparam int MaxLayers  = 4;
  localparam int MaxNeurons = 16;
  localparam int ValueWidth = 16;
  localparam int SigEntries = 256;
  localparam int FracBits   = 12;

  localparam int CntW  = $clog2(MaxNeurons + 1);
  localparam int IdxW  = $clog2(MaxNeurons);
  localparam int LyrW  = $clog2(MaxLayers);
  localparam int WAddrW = LyrW + 2 * IdxW;
  localparam int BAddrW = LyrW + IdxW;
  localparam int SigW   = $clog2(SigEntries);

  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [2:0] REG_INPUT_SIZE  = 3'd0;
  localparam logic [2:0] REG_LAYER_COUNT = 3'd1;
  localparam logic [2:0] REG_LAYER0_SIZE = 3'd2;
  localparam logic [2:0] REG_LAYER3_SIZE = 3'd5;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         layer_sel;
    logic [3:0]         neuron_sel;
    logic [3:0]         slot;
    logic signed [15:0] data_value;
    logic               vector_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [15:0] out_value;
    logic               out_last;
    logic               size_error;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_NSTART, S_MAC, S_DRAIN, S_ACT, S_OUT, S_ERR
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic            in_take;
    logic            start;
    logic            acc_clr;
    logic            bias_rd;
    logic            mac_en;
    logic            act_wr;
    logic            layer_done;
    logic            out_load;
    logic            out_err;
    logic            out_last;
    logic [LyrW-1:0] lyr;
    logic [IdxW-1:0] nrn;
    logic [IdxW-1:0] idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_full;
  } ctl_stat_t;

  typedef logic signed [ValueWidth-1:0] sig_tab_t [SigEntries];

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic longint unsigned udiv(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-x sigmoid in Q4.12, entry k covers sums from -8 + k/16.
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t            tab;
    longint              x;
    longint unsigned     t, f, n, term, sum, den, num;
    for (int k = 0; k < SigEntries; k++) begin
      x = -(longint'(1) << (ValueWidth - 1)) +
          ((longint'(k) << ValueWidth) >> SigW);
      t = (x < 0) ? longint'(-x) : longint'(x);
      f = t & ((64'd1 << FracBits) - 1);
      n = t >> FracBits;
      term = 64'd1 << 31;
      sum  = 64'd1 << 31;
      for (int i = 1; i <= 12; i++) begin
        term = udiv(term * f, 64'd4096 * longint'(i));
        if ((i & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      while (n > 0 && sum != 0) begin
        sum = (sum * 64'd790015084) >> 31;
        n = n - 1;
      end
      den = (64'd1 << 31) + sum;
      num = (x >= 0) ? ((64'd1 << 31) << FracBits) : (sum << FracBits);
      tab[k] = ValueWidth'(udiv(num + (den >> 1), den));
    end
    return tab;
  endfunction

  localparam sig_tab_t SigTab = build_sig_tab();

endpackage

### rtl/mlp_forward_pass_core.sv
// Throughput: one item per cycle while loading; the forward pass is bound by the single
//   multiply-accumulate unit and the one-read weight memory (one weight per cycle).
// Results leave one per cycle when not stalled. Reset (rst, synchronous) restores the
//   configuration defaults and clears the input vector and sample count.
// ----------------------------------------------------------------------------
// mlp_forward_pass_core
// Top level: fixed-point MLP inference with weight/bias load and sample input.
// ----------------------------------------------------------------------------
module mlp_forward_pass_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [4:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mfp_pkg::out_item_t  out_data
);

  mfp_pkg::ctl_cmd_t  cmd;
  mfp_pkg::ctl_stat_t stat;

  mfp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_item(in_data), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  mfp_dp u_dp (
    .clk(clk), .rst(rst),
    .in_item(in_data), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_data)
  );

endmodule

### rtl/mfp_ctrl.sv
// ----------------------------------------------------------------------------
// mfp_ctrl
// Sequencer: configuration, sample counting, layer/neuron/MAC walk, output.
// ----------------------------------------------------------------------------
module mfp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [4:0]           cfg_data,
  input  logic                 in_valid,
  input  mfp_pkg::in_item_t    in_item,
  output logic                 in_stall,
  input  mfp_pkg::ctl_stat_t   stat,
  output mfp_pkg::ctl_cmd_t    cmd
);

  localparam int CntW = mfp_pkg::CntW;
  localparam int LyrW = mfp_pkg::LyrW;
  localparam int IdxW = mfp_pkg::IdxW;

  mfp_pkg::state_t state, state_next;
  logic [4:0] input_size;
  logic [2:0] layer_count;
  logic [4:0] lsize [mfp_pkg::MaxLayers];
  logic [4:0] sample_count, sample_count_next;
  logic [LyrW-1:0] lyr, lyr_next;
  logic [CntW-1:0] nrn, nrn_next, idx, idx_next, oidx, oidx_next;
  logic [CntW-1:0] prevn, prevn_next, cur_n, cur_n_next;
  logic drain, drain_next;
  logic [2:0] lc_eff;
  logic accept, out_ready, bad_size;

  function automatic logic [CntW-1:0] eff_size(input logic [4:0] v);
    if (v == 5'd0) return CntW'(1);
    if (v > 5'(mfp_pkg::MaxNeurons)) return CntW'(mfp_pkg::MaxNeurons);
    return CntW'(v);
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != mfp_pkg::S_IDLE);
  assign out_ready = !stat.out_full;
  assign lc_eff    = (layer_count == 3'd0) ? 3'd1 :
                     (layer_count > 3'(mfp_pkg::MaxLayers)) ? 3'(mfp_pkg::MaxLayers) :
                     layer_count;
  assign sample_count_next = (sample_count < 5'd31) ? sample_count + 5'd1 : sample_count;
  assign bad_size = (sample_count_next != input_size) || (input_size == 5'd0) ||
                    (input_size > 5'(mfp_pkg::MaxNeurons));

  always_ff @(posedge clk) begin
    if (rst) begin
      input_size  <= 5'd16;
      layer_count <= 3'd2;
      for (int k = 0; k < mfp_pkg::MaxLayers; k++) lsize[k] <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index) inside
        mfp_pkg::REG_INPUT_SIZE:  input_size  <= cfg_data;
        mfp_pkg::REG_LAYER_COUNT: layer_count <= cfg_data[2:0];
        [mfp_pkg::REG_LAYER0_SIZE:mfp_pkg::REG_LAYER3_SIZE]:
          lsize[LyrW'(cfg_index - mfp_pkg::REG_LAYER0_SIZE)] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mfp_pkg::S_IDLE;
      sample_count <= 5'd0;
      lyr   <= '0;
      nrn   <= '0;
      idx   <= '0;
      oidx  <= '0;
      prevn <= '0;
      cur_n <= '0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_item.func == mfp_pkg::FUNC_SAMPLE)
        sample_count <= in_item.vector_end ? 5'd0 : sample_count_next;
      lyr   <= lyr_next;
      nrn   <= nrn_next;
      idx   <= idx_next;
      oidx  <= oidx_next;
      prevn <= prevn_next;
      cur_n <= cur_n_next;
      drain <= drain_next;
    end
  end

  always_comb begin
    state_next = state;
    lyr_next   = lyr;
    nrn_next   = nrn;
    idx_next   = idx;
    oidx_next  = oidx;
    prevn_next = prevn;
    cur_n_next = cur_n;
    drain_next = drain;
    cmd = '0;
    cmd.in_take = accept;
    cmd.lyr = lyr;
    cmd.nrn = nrn[IdxW-1:0];
    cmd.idx = idx[IdxW-1:0];
    case (state)
      mfp_pkg::S_IDLE: begin
        if (accept && in_item.func == mfp_pkg::FUNC_SAMPLE && in_item.vector_end)
          state_next = bad_size ? mfp_pkg::S_ERR : mfp_pkg::S_START;
      end
      mfp_pkg::S_START: begin
        cmd.start  = 1'b1;
        lyr_next   = '0;
        nrn_next   = '0;
        prevn_next = CntW'(input_size);
        cur_n_next = eff_size(lsize[0]);
        state_next = mfp_pkg::S_NSTART;
      end
      mfp_pkg::S_NSTART: begin
        cmd.acc_clr = 1'b1;
        cmd.bias_rd = 1'b1;
        idx_next    = '0;
        state_next  = mfp_pkg::S_MAC;
      end
      mfp_pkg::S_MAC: begin
        cmd.mac_en = 1'b1;
        if (idx + CntW'(1) == prevn) begin
          drain_next = 1'b0;
          state_next = mfp_pkg::S_DRAIN;
        end else begin
          idx_next = idx + CntW'(1);
        end
      end
      mfp_pkg::S_DRAIN: begin
        // wait out the two MAC pipeline stages
        drain_next = 1'b1;
        if (drain) state_next = mfp_pkg::S_ACT;
      end
      mfp_pkg::S_ACT: begin
        cmd.act_wr = 1'b1;
        if (nrn + CntW'(1) < cur_n) begin
          nrn_next   = nrn + CntW'(1);
          state_next = mfp_pkg::S_NSTART;
        end else begin
          cmd.layer_done = 1'b1;
          nrn_next = '0;
          if (3'(lyr) + 3'd1 < lc_eff) begin
            lyr_next   = lyr + LyrW'(1);
            prevn_next = cur_n;
            cur_n_next = eff_size(lsize[lyr + LyrW'(1)]);
            state_next = mfp_pkg::S_NSTART;
          end else begin
            oidx_next  = '0;
            state_next = mfp_pkg::S_OUT;
          end
        end
      end
      mfp_pkg::S_OUT: begin
        cmd.idx = oidx[IdxW-1:0];
        if (out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (oidx + CntW'(1) == cur_n);
          if (oidx + CntW'(1) == cur_n) state_next = mfp_pkg::S_IDLE;
          else oidx_next = oidx + CntW'(1);
        end
      end
      mfp_pkg::S_ERR: begin
        if (out_ready) begin
          cmd.out_err = 1'b1;
          state_next  = mfp_pkg::S_IDLE;
        end
      end
      default: state_next = mfp_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/mfp_dp.sv
// ----------------------------------------------------------------------------
// mfp_dp
// Datapath: weight/bias memories, vectors, pipelined MAC, sigmoid, output reg.
// ----------------------------------------------------------------------------
module mfp_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  mfp_pkg::in_item_t    in_item,
  input  mfp_pkg::ctl_cmd_t    cmd,
  output mfp_pkg::ctl_stat_t   stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mfp_pkg::out_item_t   out_item
);

  localparam int VW = mfp_pkg::ValueWidth;
  localparam int NN = mfp_pkg::MaxNeurons;
  localparam int IdxW = mfp_pkg::IdxW;
  localparam logic signed [VW+1:0] VMax = (VW+2)'((1 << (VW - 1)) - 1);
  localparam logic signed [VW+1:0] VMin = -VMax - (VW+2)'(1);
  localparam logic signed [2*VW:0] PMax = (2*VW+1)'(VMax);
  localparam logic signed [2*VW:0] PMin = (2*VW+1)'(VMin);

  logic signed [VW-1:0] wmem [1 << mfp_pkg::WAddrW];
  logic signed [VW-1:0] bmem [1 << mfp_pkg::BAddrW];
  logic signed [VW-1:0] inbuf [NN];
  logic signed [VW-1:0] prev  [NN];
  logic signed [VW-1:0] cur   [NN];
  logic signed [VW-1:0] w_q, a_q, b_q, acc;
  logic signed [2*VW-1:0] prod;
  logic v1, v2;
  logic signed [2*VW:0] acc_sum;
  logic signed [VW+1:0] act_sum;
  logic signed [VW-1:0] act_val, sig_val;
  logic [mfp_pkg::SigW-1:0] sig_k;

  always_ff @(posedge clk) begin
    if (cmd.in_take && in_item.func == mfp_pkg::FUNC_WEIGHT)
      wmem[{in_item.layer_sel, in_item.neuron_sel, in_item.slot}] <= in_item.data_value;
    if (cmd.mac_en) begin
      w_q <= wmem[{cmd.lyr, cmd.nrn, cmd.idx}];
      a_q <= prev[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take && in_item.func == mfp_pkg::FUNC_BIAS)
      bmem[{in_item.layer_sel, in_item.neuron_sel}] <= in_item.data_value;
    if (cmd.bias_rd) b_q <= bmem[{cmd.lyr, cmd.nrn}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NN; k++) inbuf[k] <= '0;
    end else if (cmd.in_take && in_item.func == mfp_pkg::FUNC_SAMPLE) begin
      inbuf[in_item.slot] <= in_item.data_value;
    end
  end

  // floor of product / 2^12, saturated accumulate
  assign acc_sum = (2*VW+1)'(acc) + (2*VW+1)'(prod >>> mfp_pkg::FracBits);
  // top bits of the sum, offset by the table origin, select the entry
  assign sig_k   = {~acc[VW-1], acc[VW-2 -: mfp_pkg::SigW-1]};
  assign sig_val = mfp_pkg::SigTab[sig_k];
  assign act_sum = (VW+2)'(sig_val) + (VW+2)'(b_q);
  assign act_val = (act_sum > VMax) ? VW'(VMax) : (act_sum < VMin) ? VW'(VMin) : VW'(act_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_en;
      v2 <= v1;
    end
    prod <= w_q * a_q;
    if (cmd.acc_clr) acc <= '0;
    else if (v2) acc <= (acc_sum > PMax) ? VW'(VMax) :
                        (acc_sum < PMin) ? VW'(VMin) : VW'(acc_sum);
    if (cmd.act_wr) cur[cmd.nrn] <= act_val;
    if (cmd.start) prev <= inbuf;
    else if (cmd.layer_done) begin
      for (int k = 0; k < NN; k++) prev[k] <= (k == int'(cmd.nrn)) ? act_val : cur[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load || cmd.out_err) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.out_err) begin
      out_item <= '{out_index: '0, out_value: '0, out_last: 1'b1, size_error: 1'b1};
    end else if (cmd.out_load) begin
      out_item <= '{out_index: 4'(cmd.idx), out_value: prev[cmd.idx],
                    out_last: cmd.out_last, size_error: 1'b0};
    end
  end

  assign stat.out_full = out_valid && out_stall;

endmodule

### rtl/mfp_checker.sv
// ----------------------------------------------------------------------------
// mfp_checker
// Port-level checks of the MLP forward-pass core, bound to the top level.
// ----------------------------------------------------------------------------
`include "mlp_forward_pass_core_defines.svh"

module mfp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input mfp_pkg::out_item_t out_data
);

  `MFP_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `MFP_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
  `MFP_ASSERT(a_err_form, clk, rst, out_valid && out_data.size_error |-> out_data.out_last && out_data.out_index == 4'd0 && out_data.out_value == 16'sd0, "malformed error result")
  `MFP_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !out_valid && !in_stall, "reset left the block busy")

endmodule

bind mlp_forward_pass_core mfp_checker u_mfp_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### sim/mlp_forward_pass_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlp_forward_pass_core_checker
// Watches the config port and both item channels; on each well-sized vector
// end runs its own fixed-point forward pass, and compares each result item.
// ----------------------------------------------------------------------------
module mlp_forward_pass_core_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [4:0]                  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  mfp_pkg::in_item_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  mfp_pkg::out_item_t          out_data,
  output int                          errors,
  output int                          pending,
  output int                          checked
);

  logic signed [15:0]  sigmoid_lut [256];
  logic signed [15:0]  weights [4][16][16];
  logic signed [15:0]  biases [4][16];
  logic signed [15:0]  samples [16];
  logic [4:0]          n_inputs, n_layers;
  logic [4:0]          lsize [4];
  int                  sample_cnt;
  mfp_pkg::out_item_t  expected_q [$];

  // Sigmoid in Q4.12 via a truncated Q31 e^-x series.
  function automatic void fill_sigmoid();
    longint          x;
    longint unsigned t, frac, whole, term, acc, den, num;
    for (int k = 0; k < 256; k++) begin
      x = -32768 + ((longint'(k) << 16) / 256);
      t = (x < 0) ? -x : x;
      frac = t & 4095;
      whole = t >> 12;
      term = 64'd1 << 31;
      acc = term;
      for (int i = 1; i <= 12; i++) begin
        term = (term * frac) / (64'd4096 * i);
        acc = (i % 2) ? acc - term : acc + term;
      end
      while (whole > 0 && acc != 0) begin
        acc = (acc * 64'd790015084) >> 31;
        whole--;
      end
      den = (64'd1 << 31) + acc;
      num = (x >= 0) ? (64'd1 << 43) : (acc << 12);
      sigmoid_lut[k] = 16'((num + den / 2) / den);
    end
  endfunction

  function automatic longint clamp16(longint v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic int eff(logic [4:0] v);
    return (v == 0) ? 1 : (v > 16) ? 16 : v;
  endfunction

  task automatic forward_pass();
    longint             prev [16], cur [16];
    longint             acc, prod;
    int                 nprev, n, lc;
    mfp_pkg::out_item_t r;
    lc = (n_layers == 0) ? 1 : (n_layers > 4) ? 4 : n_layers;
    for (int i = 0; i < 16; i++) prev[i] = samples[i];
    nprev = n_inputs;
    n = 1;
    for (int l = 0; l < lc; l++) begin
      n = eff(lsize[l]);
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int i = 0; i < nprev; i++) begin
          prod = prev[i] * longint'(weights[l][j][i]);
          acc = clamp16(acc + (prod >>> 12));
        end
        cur[j] = clamp16(longint'(sigmoid_lut[(acc + 32768) >> 8]) + biases[l][j]);
      end
      for (int j = 0; j < n; j++) prev[j] = cur[j];
      nprev = n;
    end
    for (int j = 0; j < n; j++) begin
      r.out_index = 4'(j);
      r.out_value = 16'(prev[j]);
      r.out_last = (j == n - 1);
      r.size_error = 1'b0;
      expected_q.push_back(r);
    end
  endtask

  task automatic take_item(mfp_pkg::in_item_t it);
    mfp_pkg::out_item_t r;
    case (it.func)
      mfp_pkg::FUNC_WEIGHT: weights[it.layer_sel][it.neuron_sel][it.slot] = it.data_value;
      mfp_pkg::FUNC_BIAS:   biases[it.layer_sel][it.neuron_sel] = it.data_value;
      mfp_pkg::FUNC_SAMPLE: begin
        samples[it.slot] = it.data_value;
        if (sample_cnt < 31) sample_cnt++;
        if (it.vector_end) begin
          if (sample_cnt != n_inputs || n_inputs == 0 || n_inputs > 16) begin
            r = '{out_index: 4'd0, out_value: 16'sd0, out_last: 1'b1, size_error: 1'b1};
            expected_q.push_back(r);
          end else begin
            forward_pass();
          end
          sample_cnt = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare(mfp_pkg::out_item_t got);
    mfp_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result item: index %0d value %0d", got.out_index, got.out_value);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.out_index !== want.out_index) begin
      $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
      errors++;
    end
    if (got.out_value !== want.out_value) begin
      $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
      errors++;
    end
    if (got.out_last !== want.out_last) begin
      $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
      errors++;
    end
    if (got.size_error !== want.size_error) begin
      $error("size_error: expected %0b, got %0b", want.size_error, got.size_error);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    checked = 0;
    pending = 0;
    fill_sigmoid();
  end

  always @(posedge clk) begin
    if (rst) begin
      n_inputs = 16;
      n_layers = 2;
      for (int i = 0; i < 4; i++) lsize[i] = 16;
      for (int i = 0; i < 16; i++) samples[i] = 0;
      sample_cnt = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mfp_pkg::REG_INPUT_SIZE:  n_inputs = cfg_data;
          mfp_pkg::REG_LAYER_COUNT: n_layers = {2'b00, cfg_data[2:0]};
          default: if (cfg_index <= mfp_pkg::REG_LAYER3_SIZE)
            lsize[cfg_index - mfp_pkg::REG_LAYER0_SIZE] = cfg_data;
        endcase
      end
      if (in_valid && !in_stall) take_item(in_data);
      if (out_valid && !out_stall) compare(out_data);
    end
    pending = expected_q.size();
  end

  final begin
    if (expected_q.size() != 0) $error("%0d result items never arrived", expected_q.size());
  end
endmodule

### sim/tb_mlp_forward_pass_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mlp_forward_pass_core
// Loads the weights and biases in use, then drives directed and random sample
// vectors under several layer configurations with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_mlp_forward_pass_core;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [4:0]          cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mfp_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mfp_pkg::out_item_t  out_data;
  int                  errors, pending, checked;
  int                  vectors = 0;
  bit                  no_gaps = 1'b0;
  logic [4:0]          cur_inputs = 5'd16;

  always #5 clk = ~clk;

  mlp_forward_pass_core uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  mlp_forward_pass_core_checker chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .errors, .pending, .checked
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Output stalls in bursts: short ones mostly, long ones now and then.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  end

  task automatic send(mfp_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put(logic [1:0] f, logic [1:0] l, logic [3:0] n, logic [3:0] s,
                     logic [15:0] d, logic e);
    mfp_pkg::in_item_t it;
    it = '{func: f, layer_sel: l, neuron_sel: n, slot: s, data_value: d, vector_end: e};
    if (f == mfp_pkg::FUNC_SAMPLE && e) vectors++;
    send(it);
  endtask

  // Hold until every expected result is back, then let the core settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(logic [4:0] ins, logic [4:0] lc, logic [4:0] s0,
                           logic [4:0] s1, logic [4:0] s2, logic [4:0] s3);
    logic [4:0] v [6];
    v = '{ins, lc, s0, s1, s2, s3};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_inputs = ins;
  endtask

  function automatic logic [15:0] rand_value();
    if ($urandom_range(3) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(4096)) - 2048);
  endfunction

  // Well-formed vector of n samples in shuffled slots, end marked on the last.
  task automatic send_vector(int n);
    int order [16];
    int j, t;
    for (int i = 0; i < 16; i++) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < n; i++)
      put(mfp_pkg::FUNC_SAMPLE, 2'($urandom()), 4'($urandom()), 4'(order[i % 16]),
          rand_value(), i == n - 1);
  endtask

  initial begin
    logic [4:0] p [6];
    int         items, n, r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load the first three neurons of every layer; every pass stays within them.
    no_gaps = 1'b1;
    for (int l = 0; l < 4; l++)
      for (int j = 0; j < 3; j++) begin
        put(mfp_pkg::FUNC_BIAS, 2'(l), 4'(j), 4'($urandom()), rand_value(),
            1'($urandom()));
        for (int i = 0; i < 3; i++)
          put(mfp_pkg::FUNC_WEIGHT, 2'(l), 4'(j), 4'(i), rand_value(), 1'($urandom()));
      end
    no_gaps = 1'b0;
    drain();

    // Directed: saturating extremes, ignored function code, size errors.
    configure(5'd2, 5'd1, 5'd2, 5'd1, 5'd1, 5'd1);
    put(mfp_pkg::FUNC_WEIGHT, 2'd0, 4'd0, 4'd0, 16'h7FFF, 1'b1);
    put(mfp_pkg::FUNC_WEIGHT, 2'd0, 4'd0, 4'd1, 16'h8000, 1'b0);
    put(mfp_pkg::FUNC_WEIGHT, 2'd0, 4'd1, 4'd0, 16'h7FFF, 1'b0);
    put(mfp_pkg::FUNC_WEIGHT, 2'd0, 4'd1, 4'd1, 16'h7FFF, 1'b0);
    put(mfp_pkg::FUNC_BIAS, 2'd0, 4'd0, 4'd0, 16'h7FFF, 1'b0);
    put(mfp_pkg::FUNC_BIAS, 2'd0, 4'd1, 4'd0, 16'h8000, 1'b0);
    put(mfp_pkg::FUNC_NONE, 2'd3, 4'd15, 4'd15, 16'hFFFF, 1'b1);
    put(mfp_pkg::FUNC_SAMPLE, 2'd3, 4'd15, 4'd0, 16'h8000, 1'b0);
    put(mfp_pkg::FUNC_SAMPLE, 2'd0, 4'd0, 4'd1, 16'h7FFF, 1'b1);
    put(mfp_pkg::FUNC_SAMPLE, 2'd0, 4'd0, 4'd15, 16'h7FFF, 1'b0);
    put(mfp_pkg::FUNC_SAMPLE, 2'd0, 4'd0, 4'd0, 16'h7FFF, 1'b1);
    put(mfp_pkg::FUNC_SAMPLE, 2'd0, 4'd0, 4'd0, 16'h0000, 1'b1);
    for (int i = 0; i < 3; i++)
      put(mfp_pkg::FUNC_SAMPLE, 2'd0, 4'd0, 4'(i), 16'h0001, i == 2);
    put(mfp_pkg::FUNC_SAMPLE, 2'd0, 4'd0, 4'd0, 16'hFFFF, 1'b0);
    put(mfp_pkg::FUNC_SAMPLE, 2'd0, 4'd0, 4'd1, 16'h1000, 1'b1);
    drain();

    // Random phases: minimum, maximum, out-of-range, then random sizes.
    items = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: p = '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1};
        1: p = '{5'd3, 5'd4, 5'd3, 5'd3, 5'd3, 5'd3};
        2: p = '{5'd3, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
        3: p = '{5'd2, 5'd7, 5'd3, 5'd2, 5'd3, 5'd0};
        4: p = '{5'd0, 5'd2, 5'd3, 5'd3, 5'd3, 5'd3};
        5: p = '{5'd17, 5'd1, 5'd3, 5'd3, 5'd3, 5'd3};
        default: begin
          p[0] = 5'($urandom_range(3, 1));
          p[1] = 5'($urandom_range(4, 1));
          for (int i = 2; i < 6; i++) p[i] = 5'($urandom_range(3, 1));
        end
      endcase
      configure(p[0], p[1], p[2], p[3], p[4], p[5]);
      no_gaps = (ph == 6);
      n = 0;
      while (n < 7) begin
        r = $urandom_range(99);
        if (r < 20) begin
          put($urandom_range(1) ? mfp_pkg::FUNC_BIAS : mfp_pkg::FUNC_WEIGHT,
              2'($urandom()), 4'($urandom()), 4'($urandom()),
              rand_value(), 1'($urandom()));
          n++;
        end else if (r < 25) begin
          put(mfp_pkg::FUNC_NONE, 2'($urandom()), 4'($urandom()), 4'($urandom()),
              16'($urandom()), 1'($urandom()));
        end else if (r < 85 && cur_inputs >= 1 && cur_inputs <= 16) begin
          send_vector(cur_inputs);
          n += cur_inputs;
        end else begin
          r = (cur_inputs <= 1) ? 2 : cur_inputs + ($urandom_range(1) ? 1 : -1);
          if (r > 4) r = 2;
          send_vector(r);
          n += r;
        end
      end
      items += n;
      no_gaps = 1'b0;
      drain();
    end

    $display("Ran %0d vectors (%0d random items) over 9 configurations;", vectors, items);
    $display("%0d result items checked, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
